[rtl/ltrg_pkg.sv]
// ----------------------------------------------------------------------------
// ltrg_pkg
// Shared types, constants and helper functions for the lagged table random
// generator unit.
// ----------------------------------------------------------------------------
package ltrg_pkg;

  localparam int RING_DEPTH  = 96;
  localparam int WORD_BITS   = 32;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int SEED_BITS   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SEED_BITS-1:0] SEED_MUL = 16'd20077;
  localparam logic [SEED_BITS-1:0] SEED_ADD = 16'd11;

  // Kind codes on the command port; the fourth code is unused.
  typedef enum logic [1:0] {
    OP_SEED_START = 2'd0,
    OP_SEED_BIT   = 2'd1,
    OP_DRAW       = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [SEED_BITS-1:0] seed_value;
    logic                 seed_bit;
  } cmd_t;

  // One congruential step: x*20077 + 11 mod 2^16.
  function automatic logic [SEED_BITS-1:0] seed_step(input logic [SEED_BITS-1:0] x);
    logic [2*SEED_BITS-1:0] p;
    p = (2*SEED_BITS)'(x) * (2*SEED_BITS)'(SEED_MUL) + (2*SEED_BITS)'(SEED_ADD);
    return p[SEED_BITS-1:0];
  endfunction

  // Seed state mod 96: 96 = 32 * 3, so keep the low five bits and take the
  // upper eleven bits mod 3 by summing base-4 digits (4 is 1 mod 3).
  function automatic logic [RING_AW-1:0] seed_slot(input logic [SEED_BITS-1:0] x);
    logic [10:0] hi;
    logic [4:0]  s;
    hi = x[15:5];
    s  = 5'(hi[1:0]) + 5'(hi[3:2]) + 5'(hi[5:4]) + 5'(hi[7:6]) + 5'(hi[9:8])
       + 5'(hi[10]);
    if (s >= 5'd12) s = s - 5'd12;
    if (s >= 5'd6)  s = s - 5'd6;
    if (s >= 5'd3)  s = s - 5'd3;
    return {s[1:0], x[4:0]};
  endfunction

  // Circular address: head plus a small offset, wrapped at the ring depth.
  function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] h,
                                                  input logic [2:0] off);
    logic [RING_AW:0] s;
    s = (RING_AW+1)'(h) + (RING_AW+1)'(off);
    if (s >= (RING_AW+1)'(RING_DEPTH)) s = s - (RING_AW+1)'(RING_DEPTH);
    return s[RING_AW-1:0];
  endfunction

  // Read order of a draw: five lagged taps, then the head word itself.
  function automatic logic [2:0] draw_offset(input logic [2:0] step);
    logic [2:0] off;
    unique case (step)
      3'd0:    off = 3'd7;
      3'd1:    off = 3'd6;
      3'd2:    off = 3'd4;
      3'd3:    off = 3'd3;
      3'd4:    off = 3'd2;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

[rtl/ltrg_ram.sv]
// ----------------------------------------------------------------------------
// ltrg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ltrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ltrg_front.sv]
// ----------------------------------------------------------------------------
// ltrg_front
// Command intake: decodes the kind field, drops unused codes and queues
// commands for the back end.
// ----------------------------------------------------------------------------
module ltrg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    kind,
  input  logic [ltrg_pkg::SEED_BITS-1:0] seed_value,
  input  logic                          seed_bit,
  output logic                          busy,
  output logic                          cmd_valid,
  output ltrg_pkg::cmd_t                cmd,
  input  logic                          cmd_pop
);
  import ltrg_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          queue [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  cmd_t          in_cmd;
  logic          push;
  logic          pop;

  always_comb begin
    in_cmd.seed_value = seed_value;
    in_cmd.seed_bit   = seed_bit;
    unique case (kind)
      2'd0:    in_cmd.op = OP_SEED_START;
      2'd1:    in_cmd.op = OP_SEED_BIT;
      2'd2:    in_cmd.op = OP_DRAW;
      default: in_cmd.op = OP_NONE;
    endcase
  end

  assign busy      = (count == CW'(QUEUE_DEPTH));
  // Drop unused codes here: they take the transaction but change nothing.
  assign push      = start && !busy && (in_cmd.op != OP_NONE);
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/ltrg_back.sv]
// ----------------------------------------------------------------------------
// ltrg_back
// Execution sequencer: owns the ring RAM, its valid bits, the head index and
// the seed state, and carries out one queued command at a time.
// ----------------------------------------------------------------------------
module ltrg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  ltrg_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  output logic                          done,
  output logic [ltrg_pkg::WORD_BITS-1:0] number
);
  import ltrg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_DRAW       = 5'b00010,
    ST_FLIP_ADV   = 5'b00100,
    ST_FLIP_READ  = 5'b01000,
    ST_FLIP_WRITE = 5'b10000
  } state_t;

  localparam logic [2:0] DRAW_LAST = 3'd6;
  localparam logic [2:0] FLIP_LAST = 3'd4;

  state_t                state;
  state_t                state_next;
  logic [2:0]            step;
  logic [RING_AW-1:0]    head;
  logic [SEED_BITS-1:0]  seed;
  logic [RING_DEPTH-1:0] ring_valid;
  logic [RING_AW-1:0]    slot;
  logic [WORD_BITS-1:0]  acc;
  logic                  rd_ok;

  logic                  we;
  logic [RING_AW-1:0]    waddr;
  logic [WORD_BITS-1:0]  wdata;
  logic [RING_AW-1:0]    raddr;
  logic [WORD_BITS-1:0]  rdata;
  logic [WORD_BITS-1:0]  rword;
  logic [WORD_BITS-1:0]  sum;

  ltrg_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Entries not written since the last clear read as zero.
  assign rword   = rd_ok ? rdata : '0;
  assign sum     = rword + acc;
  assign cmd_pop = (state == ST_IDLE) && cmd_valid;

  always_comb begin
    if (state == ST_FLIP_READ) begin
      raddr = seed_slot(seed);
    end else begin
      raddr = ring_add(head, draw_offset(step));
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = head;
    wdata = sum;
    if ((state == ST_DRAW) && (step == DRAW_LAST)) begin
      we = 1'b1;
    end else if (state == ST_FLIP_WRITE) begin
      we    = 1'b1;
      waddr = slot;
      wdata = rword ^ WORD_BITS'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_DRAW) begin
            state_next = ST_DRAW;
          end else if ((cmd.op == OP_SEED_BIT) && cmd.seed_bit) begin
            state_next = ST_FLIP_ADV;
          end
        end
      end
      ST_DRAW: begin
        if (step == DRAW_LAST) state_next = ST_IDLE;
      end
      ST_FLIP_ADV:   state_next = ST_FLIP_READ;
      ST_FLIP_READ:  state_next = ST_FLIP_WRITE;
      ST_FLIP_WRITE: state_next = (step == FLIP_LAST) ? ST_IDLE : ST_FLIP_ADV;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_ok <= ring_valid[raddr];
    if (state == ST_FLIP_READ) begin
      slot <= raddr;
    end
    if (state == ST_IDLE) begin
      acc <= '0;
    end else if ((state == ST_DRAW) && (step != 3'd0) && (step != DRAW_LAST)) begin
      acc <= acc ^ rword;
    end
    if ((state == ST_DRAW) && (step == DRAW_LAST)) begin
      number <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      head       <= '0;
      seed       <= '0;
      ring_valid <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DRAW) && (step == DRAW_LAST);
      if (we) begin
        ring_valid[waddr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (cmd_valid) begin
            unique case (cmd.op)
              OP_SEED_START: begin
                ring_valid <= '0;
                head       <= '0;
                seed       <= cmd.seed_value;
              end
              OP_SEED_BIT: seed <= seed_step(seed);
              OP_DRAW: begin
                head <= (head == '0 || head >= RING_AW'(RING_DEPTH))
                      ? RING_AW'(RING_DEPTH - 1) : head - 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_DRAW:       step <= step + 1'b1;
        ST_FLIP_ADV:   seed <= seed_step(seed);
        ST_FLIP_READ:  ;
        ST_FLIP_WRITE: step <= step + 1'b1;
        default:       ;
      endcase
    end
  end

endmodule

[rtl/lagged_table_random_generator_unit.sv]
// ----------------------------------------------------------------------------
// lagged_table_random_generator_unit
// Lagged additive random generator over a 96-word ring, with congruential
// seeding.
// ----------------------------------------------------------------------------
// A draw shows its number on the done strobe after its start transaction
// has passed the command queue, the dispatch in the idle state and the ring
// RAM steps of the draw state. The back end takes one command at a time: a
// draw's length is set by six reads through the single read port of the ring
// RAM and one write, a seed start and a clear seed bit are done in the idle
// state alone, and a set seed bit runs five read-flip-write passes. Reset
// (rst, synchronous) empties the queue, zeroes head and seed state and marks
// every ring word as zero; results cannot be stalled.
// ----------------------------------------------------------------------------
module lagged_table_random_generator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    kind,
  input  logic [ltrg_pkg::SEED_BITS-1:0] seed_value,
  input  logic                          seed_bit,
  output logic                          busy,
  output logic                          done,
  output logic [ltrg_pkg::WORD_BITS-1:0] number
);
  import ltrg_pkg::*;

  // Command queue handoff between intake and execution.
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Front end: take a transaction whenever the queue has room, decode its
  // kind and drop the unused code without touching any state.
  ltrg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .seed_value(seed_value),
    .seed_bit  (seed_bit),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: advance the head and fold the lagged taps into the head word
  // for draws; advance the seed state and flip ring bits for seeding. The
  // ring lives in RAM with per-word valid bits, so a seed start clears the
  // whole table by clearing those bits, without writing the RAM.
  ltrg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .done     (done),
    .number   (number)
  );

endmodule
